### src/page_window_allocator_macros.svh
// ----------------------------------------------------------------------------
// Page window allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_WINDOW_ALLOCATOR_MACROS_SVH
`define PAGE_WINDOW_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PWA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PWA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define PWA_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/pwa_pkg.sv
// ----------------------------------------------------------------------------
// Page window allocator package
// Sizes, status codes, opcodes and sequencer states of the allocator.
// ----------------------------------------------------------------------------
package pwa_pkg;

   localparam int WINDOW_PAGES = 32768;
   localparam int PAGE_W       = $clog2(WINDOW_PAGES);
   localparam int WORD_BITS    = 32;
   localparam int BM_WORDS     = WINDOW_PAGES / WORD_BITS;
   localparam int WORD_W       = $clog2(BM_WORDS);
   localparam int REGION_SLOTS = 64;
   localparam int SLOT_W       = $clog2(REGION_SLOTS);
   localparam int CNT_W        = 16;
   localparam int VPAGE_W      = 20;
   localparam int OFFS_W       = 12;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_IGNORED    = 3'd1,
      ST_NO_SPACE   = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EVAL,
      S_MARK_RD,
      S_MARK_WR,
      S_ASLOT,
      S_FSLOT_RD,
      S_FSLOT_CHK,
      S_FREE_RD,
      S_FREE_WR,
      S_RESP
   } state_type;

endpackage

### src/pwa_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface pwa_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] source_addr;
   logic [31:0] byte_size;
   logic [31:0] release_addr;

   modport source (output valid, opcode, source_addr, byte_size, release_addr, input ready);
   modport sink   (input valid, opcode, source_addr, byte_size, release_addr, output ready);
endinterface

### src/pwa_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface pwa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] mapped_addr;
   logic [15:0] page_count;
   logic [15:0] used_pages;
   logic [15:0] free_pages;

   modport source (output valid, status, mapped_addr, page_count, used_pages, free_pages,
                   input ready);
   modport sink   (input valid, status, mapped_addr, page_count, used_pages, free_pages,
                   output ready);
endinterface

### src/pwa_csr_if.sv
// ----------------------------------------------------------------------------
// Allocator configuration channel
// Valid/ready write channel for the window base page register.
// ----------------------------------------------------------------------------
interface pwa_csr_if;
   logic        valid;
   logic        ready;
   logic [19:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### src/page_window_allocator.sv
// ----------------------------------------------------------------------------
// Page window allocator
// First-fit bitmap allocator of 4 KB pages with a region table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-word page bitmap to zero, one word per
// cycle, and takes no request until the sweep ends. One request is worked at a
// time. An allocate scans the bitmap memory from page 0, reading each word and
// then evaluating it; fully free or fully used words resolve at once, mixed
// words are evaluated four pages at a time. It then marks the run, reading and
// writing each touched word, and looks for the lowest free one of the 64 region
// slots. A free checks the region slots, reading and checking each of up to 64,
// and clears the run, reading and writing each word. Zero-size, zero-address
// and oversized requests go straight to the response. The bitmap read port sets
// the scan rate. The result sits in an output register, so a new request is
// taken while a result waits.
// ----------------------------------------------------------------------------
module page_window_allocator (
   input  logic clock,
   input  logic reset,
   pwa_req_if.sink   req_ch,
   pwa_rsp_if.source rsp_ch,
   pwa_csr_if.sink   csr_ch
);

   localparam logic [pwa_pkg::PAGE_W-1:0] LAST_PAGE = {pwa_pkg::PAGE_W{1'b1}};
   localparam logic [pwa_pkg::WORD_W-1:0] LAST_WORD = {pwa_pkg::WORD_W{1'b1}};
   localparam logic [pwa_pkg::SLOT_W-1:0] LAST_SLOT = pwa_pkg::SLOT_W'(pwa_pkg::REGION_SLOTS - 1);
   localparam logic [20:0] MAX_NEED = 21'(pwa_pkg::WINDOW_PAGES);

   // Count of set bits in a bitmap word.
   function automatic logic [5:0] popcount(input logic [31:0] w);
      logic [5:0] c;
      c = '0;
      for (int i = 0; i < 32; i++) c = c + 6'(w[i]);
      return c;
   endfunction

   // Sequencer and work registers.
   pwa_pkg::state_type state_ff, state_in;
   logic [pwa_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [2:0]                  quad_ff, quad_in;
   logic [15:0]                 run_ff, run_in;
   logic [pwa_pkg::PAGE_W-1:0]  start_ff, start_in;
   logic [pwa_pkg::PAGE_W-1:0]  rend_ff, rend_in;
   logic [15:0]                 need_ff, need_in;
   logic [11:0]                 offset_ff, offset_in;
   logic [19:0]                 vpage_ff, vpage_in;
   logic [pwa_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [15:0]                 slen_ff, slen_in;
   logic [15:0]                 used_ff, used_in;
   logic [19:0]                 base_ff, base_in;
   logic [pwa_pkg::REGION_SLOTS-1:0] valid_ff, valid_in;
   logic [2:0]                  res_status_ff, res_status_in;
   logic [31:0]                 res_addr_ff, res_addr_in;
   logic [15:0]                 res_count_ff, res_count_in;

   // Response output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [15:0] rsp_count_ff, rsp_count_in;
   logic [15:0] rsp_used_ff, rsp_used_in;
   logic [15:0] rsp_free_ff, rsp_free_in;

   // Memories and their ports.
   logic [31:0] bm_mem [pwa_pkg::BM_WORDS];
   logic [31:0] bm_rd_ff;
   logic        bm_re, bm_we;
   logic [pwa_pkg::WORD_W-1:0] bm_addr;
   logic [31:0] bm_wdata;

   logic [19:0] ss_mem [pwa_pkg::REGION_SLOTS];
   logic [15:0] sl_mem [pwa_pkg::REGION_SLOTS];
   logic [19:0] ss_rd_ff;
   logic [15:0] sl_rd_ff;
   logic        slot_re, slot_we;

   // Range mask for the word being marked or cleared.
   logic [4:0]  mask_lo, mask_hi;
   logic [31:0] range_mask;

   always_comb begin
      mask_lo = (word_ff == start_ff[pwa_pkg::PAGE_W-1:5]) ? start_ff[4:0] : 5'd0;
      mask_hi = (word_ff == rend_ff[pwa_pkg::PAGE_W-1:5]) ? rend_ff[4:0] : 5'd31;
      range_mask = ({32{1'b1}} << mask_lo) & ({32{1'b1}} >> (5'd31 - mask_hi));
   end

   assign req_ch.ready = (state_ff == pwa_pkg::S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.mapped_addr = rsp_addr_ff;
   assign rsp_ch.page_count  = rsp_count_ff;
   assign rsp_ch.used_pages  = rsp_used_ff;
   assign rsp_ch.free_pages  = rsp_free_ff;

   // Next state and datapath.
   always_comb begin
      logic [32:0] need33;
      logic [20:0] need21;
      logic [16:0] run32;
      logic [15:0] r;
      logic [pwa_pkg::PAGE_W-1:0] s;
      logic        found;
      logic        word_done;
      logic [19:0] rel;
      logic [20:0] endf;
      logic [31:0] hit;

      state_in      = state_ff;
      word_in       = word_ff;
      quad_in       = quad_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      rend_in       = rend_ff;
      need_in       = need_ff;
      offset_in     = offset_ff;
      vpage_in      = vpage_ff;
      slot_in       = slot_ff;
      slen_in       = slen_ff;
      used_in       = used_ff;
      base_in       = base_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      bm_re    = 1'b0;
      bm_we    = 1'b0;
      bm_addr  = word_ff;
      bm_wdata = '0;
      slot_re  = 1'b0;
      slot_we  = 1'b0;
      need33 = '0;
      need21 = '0;
      run32  = '0;
      r = run_ff;
      s = start_ff;
      found = 1'b0;
      word_done = 1'b0;
      rel  = '0;
      endf = '0;
      hit  = bm_rd_ff & range_mask;

      if (csr_ch.valid) begin
         base_in = csr_ch.data;
      end

      case (state_ff)
         // Sweep the bitmap to zero after reset.
         pwa_pkg::S_CLEAR: begin
            bm_we = 1'b1;
            word_in = word_ff + 1'b1;
            if (word_ff == LAST_WORD) begin
               state_in = pwa_pkg::S_IDLE;
            end
         end

         // Take a request and sort out the trivial cases.
         pwa_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               res_addr_in  = '0;
               res_count_in = '0;
               if (req_ch.opcode == pwa_pkg::OP_ALLOC) begin
                  need33 = 33'(req_ch.byte_size) + 33'(req_ch.source_addr[11:0]) + 33'h0FFF;
                  need21 = need33[32:12];
                  offset_in = req_ch.source_addr[11:0];
                  if (req_ch.byte_size == '0) begin
                     res_status_in = pwa_pkg::ST_IGNORED;
                     state_in = pwa_pkg::S_RESP;
                  end else if (need21 > MAX_NEED) begin
                     res_status_in = pwa_pkg::ST_NO_SPACE;
                     state_in = pwa_pkg::S_RESP;
                  end else begin
                     need_in  = need21[15:0];
                     run_in   = '0;
                     word_in  = '0;
                     state_in = pwa_pkg::S_SCAN_RD;
                  end
               end else begin
                  vpage_in = req_ch.release_addr[31:12];
                  slot_in  = '0;
                  if (req_ch.release_addr == '0) begin
                     res_status_in = pwa_pkg::ST_IGNORED;
                     state_in = pwa_pkg::S_RESP;
                  end else begin
                     state_in = pwa_pkg::S_FSLOT_RD;
                  end
               end
            end
         end

         pwa_pkg::S_SCAN_RD: begin
            bm_re    = 1'b1;
            quad_in  = '0;
            state_in = pwa_pkg::S_SCAN_EVAL;
         end

         // First-fit scan: whole-word fast path, else four pages per cycle.
         pwa_pkg::S_SCAN_EVAL: begin
            if (quad_ff == '0 && bm_rd_ff == '0) begin
               word_done = 1'b1;
               run32 = 17'(run_ff) + 17'd32;
               if (run_ff == '0) s = {word_ff, 5'd0};
               if (run32 >= 17'(need_ff)) found = 1'b1;
               else r = run32[15:0];
            end else if (quad_ff == '0 && bm_rd_ff == '1) begin
               word_done = 1'b1;
               r = '0;
            end else begin
               word_done = (quad_ff == 3'd7);
               for (int j = 0; j < 4; j++) begin
                  if (!found) begin
                     if (bm_rd_ff[{quad_ff, 2'(j)}]) begin
                        r = '0;
                     end else begin
                        if (r == '0) s = {word_ff, quad_ff, 2'(j)};
                        r = r + 1'b1;
                        if (r == need_ff) found = 1'b1;
                     end
                  end
               end
            end
            run_in   = r;
            start_in = s;
            quad_in  = quad_ff + 1'b1;
            if (found) begin
               rend_in  = s + need_ff[pwa_pkg::PAGE_W-1:0] - 1'b1;
               word_in  = s[pwa_pkg::PAGE_W-1:5];
               state_in = pwa_pkg::S_MARK_RD;
            end else if (word_done) begin
               if (word_ff == LAST_WORD) begin
                  res_status_in = pwa_pkg::ST_NO_SPACE;
                  state_in = pwa_pkg::S_RESP;
               end else begin
                  word_in  = word_ff + 1'b1;
                  state_in = pwa_pkg::S_SCAN_RD;
               end
            end
         end

         pwa_pkg::S_MARK_RD: begin
            bm_re    = 1'b1;
            state_in = pwa_pkg::S_MARK_WR;
         end

         // Set the run's bits one word at a time.
         pwa_pkg::S_MARK_WR: begin
            bm_we    = 1'b1;
            bm_wdata = bm_rd_ff | range_mask;
            if (word_ff == rend_ff[pwa_pkg::PAGE_W-1:5]) begin
               used_in  = used_ff + need_ff;
               vpage_in = base_ff + 20'(start_ff);
               slot_in  = '0;
               state_in = pwa_pkg::S_ASLOT;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = pwa_pkg::S_MARK_RD;
            end
         end

         // Record the run in the lowest free slot.
         pwa_pkg::S_ASLOT: begin
            res_addr_in  = {vpage_ff, offset_ff};
            res_count_in = need_ff;
            if (!valid_ff[slot_ff]) begin
               slot_we = 1'b1;
               valid_in[slot_ff] = 1'b1;
               res_status_in = pwa_pkg::ST_OK;
               state_in = pwa_pkg::S_RESP;
            end else if (slot_ff == LAST_SLOT) begin
               res_status_in = pwa_pkg::ST_TABLE_FULL;
               state_in = pwa_pkg::S_RESP;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end

         pwa_pkg::S_FSLOT_RD: begin
            slot_re  = 1'b1;
            state_in = pwa_pkg::S_FSLOT_CHK;
         end

         // Look for the lowest valid slot whose start page matches.
         pwa_pkg::S_FSLOT_CHK: begin
            if (valid_ff[slot_ff] && ss_rd_ff == vpage_ff) begin
               slen_in = sl_rd_ff;
               rel  = vpage_ff - base_ff;
               endf = 21'(rel) + 21'(sl_rd_ff) - 21'd1;
               start_in = rel[pwa_pkg::PAGE_W-1:0];
               rend_in  = (endf >= MAX_NEED) ? LAST_PAGE : endf[pwa_pkg::PAGE_W-1:0];
               word_in  = rel[pwa_pkg::PAGE_W-1:5];
               if (rel[19:pwa_pkg::PAGE_W] == '0 && sl_rd_ff != '0) begin
                  state_in = pwa_pkg::S_FREE_RD;
               end else begin
                  valid_in[slot_ff] = 1'b0;
                  res_status_in = pwa_pkg::ST_OK;
                  res_count_in  = sl_rd_ff;
                  state_in = pwa_pkg::S_RESP;
               end
            end else if (slot_ff == LAST_SLOT) begin
               res_status_in = pwa_pkg::ST_NOT_FOUND;
               state_in = pwa_pkg::S_RESP;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = pwa_pkg::S_FSLOT_RD;
            end
         end

         pwa_pkg::S_FREE_RD: begin
            bm_re    = 1'b1;
            state_in = pwa_pkg::S_FREE_WR;
         end

         // Clear the run's bits and count the pages actually released.
         pwa_pkg::S_FREE_WR: begin
            bm_we    = 1'b1;
            bm_wdata = bm_rd_ff & ~range_mask;
            used_in  = used_ff - 16'(popcount(hit));
            if (word_ff == rend_ff[pwa_pkg::PAGE_W-1:5]) begin
               valid_in[slot_ff] = 1'b0;
               res_status_in = pwa_pkg::ST_OK;
               res_count_in  = slen_ff;
               state_in = pwa_pkg::S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = pwa_pkg::S_FREE_RD;
            end
         end

         // Hand the result to the output register once it is free.
         pwa_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_count_in  = res_count_ff;
               rsp_used_in   = used_ff;
               rsp_free_in   = 16'(pwa_pkg::WINDOW_PAGES) - used_ff;
               state_in      = pwa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pwa_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwa_pkg::S_CLEAR;
         word_ff      <= '0;
         used_ff      <= '0;
         base_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         used_ff      <= used_in;
         base_ff      <= base_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      quad_ff       <= quad_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      rend_ff       <= rend_in;
      need_ff       <= need_in;
      offset_ff     <= offset_in;
      vpage_ff      <= vpage_in;
      slot_ff       <= slot_in;
      slen_ff       <= slen_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Page bitmap memory.
   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_addr] <= bm_wdata;
      if (bm_re) bm_rd_ff <= bm_mem[bm_addr];
   end

   // Region table memories.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         ss_mem[slot_ff] <= vpage_ff;
         sl_mem[slot_ff] <= need_ff;
      end
      if (slot_re) begin
         ss_rd_ff <= ss_mem[slot_ff];
         sl_rd_ff <= sl_mem[slot_ff];
      end
   end

endmodule

### src/pwa_checker.sv
// ----------------------------------------------------------------------------
// Page window allocator checker
// Port-level assertions on the allocator, attached by bind.
// ----------------------------------------------------------------------------
`include "page_window_allocator_macros.svh"

module pwa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic [31:0] mapped_addr,
   input logic [15:0] page_count,
   input logic [15:0] used_pages,
   input logic [15:0] free_pages
);

   // A waiting result stays offered.
   `PWA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // On a valid response, used and free pages add up to the window size.
   `PWA_ASSERT_NOW(a_count_sum, rsp_valid, (17'(used_pages) + 17'(free_pages)) == 17'd32768)

   // Ignored, no-space and not-found results report no pages and no address.
   `PWA_ASSERT_NOW(a_fail_empty, rsp_valid && (status == pwa_pkg::ST_IGNORED || status == pwa_pkg::ST_NO_SPACE || status == pwa_pkg::ST_NOT_FOUND), page_count == '0 && mapped_addr == '0)

   // The bitmap clearing pass keeps requests out right after reset.
   `PWA_ASSERT_ALWAYS(a_reset_busy, reset, !req_ready)

endmodule

bind page_window_allocator pwa_checker u_pwa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .status      (rsp_ch.status),
   .mapped_addr (rsp_ch.mapped_addr),
   .page_count  (rsp_ch.page_count),
   .used_pages  (rsp_ch.used_pages),
   .free_pages  (rsp_ch.free_pages)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page window allocator testbench
// Drives allocate and free requests with random gaps and response stalls.
// Each accepted request is run through a behavioral copy of the page bitmap
// and region table, and every response is checked field by field against the
// oldest predicted outcome. The window base moves between phases.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      pwa_pkg::opcode_type op;
      logic [31:0]         phys;
      logic [31:0]         size;
      logic [31:0]         rel_addr;
   } request_type;

   typedef struct {
      pwa_pkg::status_type status;
      logic [31:0]         mapped;
      logic [15:0]         count;
      logic [15:0]         used;
      logic [15:0]         free;
   } outcome_type;

   localparam int IDLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pwa_req_if req_if ();
   pwa_rsp_if rsp_if ();
   pwa_csr_if csr_if ();

   page_window_allocator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #4 clock = ~clock;

   // Shadow copy of the allocator state.
   bit          page_used [0:pwa_pkg::WINDOW_PAGES-1];
   int unsigned used_total;
   bit          slot_on   [0:pwa_pkg::REGION_SLOTS-1];
   logic [19:0] slot_page [0:pwa_pkg::REGION_SLOTS-1];
   int unsigned slot_len  [0:pwa_pkg::REGION_SLOTS-1];
   logic [19:0] window_base;

   request_type pending_q [$];
   outcome_type outcome_q [$];
   logic [19:0] live_pages [$];
   request_type cur_req;
   int          req_gap;
   int          rsp_gap;
   int          hold_left;
   bit          hold_req;
   bit          hold_done;
   int          errors;
   int          idle_cycles;
   int          n_items;

   function automatic outcome_type finish_outcome(pwa_pkg::status_type st,
                                                  logic [31:0] addr,
                                                  int unsigned cnt);
      outcome_type o;
      o.status = st;
      o.mapped = addr;
      o.count  = cnt[15:0];
      o.used   = used_total[15:0];
      o.free   = 16'(pwa_pkg::WINDOW_PAGES - used_total);
      return o;
   endfunction

   // First-fit allocation or region release on the shadow state.
   function automatic outcome_type compute_outcome(request_type r);
      logic [33:0] need;
      logic [11:0] offs;
      logic [19:0] vpage;
      logic [19:0] rel;
      int unsigned start;
      int unsigned run;
      int unsigned p;
      int          hit;
      bit          found;
      start = 0;
      run   = 0;
      found = 0;
      hit   = -1;
      if (r.op == pwa_pkg::OP_ALLOC) begin
         if (r.size == 0) return finish_outcome(pwa_pkg::ST_IGNORED, 0, 0);
         offs = r.phys[11:0];
         need = (34'(r.size) + 34'(offs) + 34'hFFF) >> 12;
         if (need <= pwa_pkg::WINDOW_PAGES) begin
            for (int q = 0; q < pwa_pkg::WINDOW_PAGES; q++) begin
               if (page_used[q]) begin
                  run = 0;
               end else begin
                  if (run == 0) start = q;
                  run++;
                  if (run == need) begin
                     found = 1;
                     break;
                  end
               end
            end
         end
         if (!found) return finish_outcome(pwa_pkg::ST_NO_SPACE, 0, 0);
         for (int unsigned i = 0; i < need; i++) page_used[start + i] = 1'b1;
         used_total += 32'(need);
         vpage = window_base + start[19:0];
         for (int i = 0; i < pwa_pkg::REGION_SLOTS; i++) begin
            if (!slot_on[i]) begin
               slot_on[i]   = 1'b1;
               slot_page[i] = vpage;
               slot_len[i]  = 32'(need);
               live_pages.push_back(vpage);
               return finish_outcome(pwa_pkg::ST_OK, {vpage, 12'h000} + 32'(offs),
                                     32'(need));
            end
         end
         return finish_outcome(pwa_pkg::ST_TABLE_FULL, {vpage, 12'h000} + 32'(offs),
                               32'(need));
      end
      if (r.rel_addr == 0) return finish_outcome(pwa_pkg::ST_IGNORED, 0, 0);
      vpage = r.rel_addr[31:12];
      for (int i = 0; i < pwa_pkg::REGION_SLOTS; i++) begin
         if (slot_on[i] && slot_page[i] == vpage) begin
            hit = i;
            break;
         end
      end
      if (hit < 0) return finish_outcome(pwa_pkg::ST_NOT_FOUND, 0, 0);
      // The run is located relative to the current window, which may have moved.
      rel = vpage - window_base;
      for (int unsigned k = 0; k < slot_len[hit]; k++) begin
         p = 32'(rel) + k;
         if (p >= pwa_pkg::WINDOW_PAGES) break;
         if (page_used[p]) begin
            page_used[p] = 1'b0;
            used_total--;
         end
      end
      slot_on[hit] = 1'b0;
      foreach (live_pages[j]) begin
         if (live_pages[j] == vpage) begin
            live_pages.delete(j);
            break;
         end
      end
      return finish_outcome(pwa_pkg::ST_OK, 0, slot_len[hit]);
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(80, 15);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      request_type nxt;
      logic        fire;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         fire = req_if.valid && req_if.ready;
         if (fire) outcome_q.push_back(compute_outcome(cur_req));
         if (fire || !req_if.valid) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               cur_req = nxt;
               req_if.opcode       <= nxt.op;
               req_if.source_addr  <= nxt.phys;
               req_if.byte_size    <= nxt.size;
               req_if.release_addr <= nxt.rel_addr;
               req_if.valid        <= 1'b1;
               req_gap = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready control.
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response, status %0d", rsp_if.status);
            end else begin
               e = outcome_q.pop_front();
               if (rsp_if.status !== e.status || rsp_if.mapped_addr !== e.mapped ||
                   rsp_if.page_count !== e.count || rsp_if.used_pages !== e.used ||
                   rsp_if.free_pages !== e.free) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp st %0d addr %h cnt %0d used %0d free %0d,",
                               " got st %0d addr %h cnt %0d used %0d free %0d"},
                              e.status, e.mapped, e.count, e.used, e.free,
                              rsp_if.status, rsp_if.mapped_addr, rsp_if.page_count,
                              rsp_if.used_pages, rsp_if.free_pages);
               end
            end
         end
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_alloc(logic [31:0] phys, logic [31:0] size);
      request_type r;
      r.op = pwa_pkg::OP_ALLOC;
      r.phys = phys;
      r.size = size;
      r.rel_addr = $urandom;
      pending_q.push_back(r);
      n_items++;
   endtask

   task automatic push_free(logic [31:0] addr);
      request_type r;
      r.op = pwa_pkg::OP_FREE;
      r.phys = $urandom;
      r.size = $urandom;
      r.rel_addr = addr;
      pending_q.push_back(r);
      n_items++;
   endtask

   // Free inside a live region, at a random offset within its first page.
   task automatic push_free_live();
      logic [19:0] vp;
      if (live_pages.size() == 0) begin
         push_free($urandom);
      end else begin
         vp = live_pages[$urandom_range(live_pages.size() - 1)];
         push_free({vp, 12'($urandom)});
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || outcome_q.size() != 0 || req_if.valid);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(logic [19:0] value);
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      window_base = value;
   endtask

   task automatic release_all_live();
      int n;
      n = live_pages.size();
      for (int i = 0; i < n; i++) push_free({live_pages[i], 12'($urandom)});
      wait_drained();
   endtask

   // Random request mix, mostly small allocations and frees of live regions.
   task automatic random_batch(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 55)      push_alloc($urandom, $urandom_range(4 * 4096, 1));
         else if (r < 62) push_alloc($urandom, $urandom_range(96 * 4096, 1));
         else if (r < 66) push_alloc($urandom, $urandom);
         else if (r < 68) push_alloc($urandom, 0);
         else if (r < 92) push_free_live();
         else if (r < 98) push_free($urandom);
         else             push_free(0);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.opcode = pwa_pkg::OP_ALLOC;
      req_if.source_addr = '0;
      req_if.byte_size = '0;
      req_if.release_addr = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      window_base = '0;
      used_total = 0;
      errors = 0;
      n_items = 0;
      hold_req = 1'b0;
      hold_done = 1'b0;
      idle_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_base(20'd0);

      // Directed: zero size, whole window, no space, zero address, huge sizes.
      push_alloc(32'h0, 32'h0);
      push_alloc(32'h0, 32'h0800_0000);
      push_alloc(32'h123, 32'h1);
      push_free(32'h0);
      push_free(32'h0000_0FFF);
      wait_drained();
      release_all_live();
      push_alloc(32'hFFFF_FFFF, 32'h1);
      push_alloc(32'h1000, 32'hFFFF_FFFF);
      push_alloc(32'h0, 32'h0800_0001);
      push_alloc(32'h0000_0001, 32'h7FFF_F000);
      push_free(32'hFFFF_FFFF);
      push_free(32'h8000_0000);
      wait_drained();
      release_all_live();

      // Region table overflow: the last allocations stay untracked.
      write_base(20'd1015807);
      for (int i = 0; i < pwa_pkg::REGION_SLOTS + 3; i++) push_alloc($urandom, 32'd4096);
      wait_drained();
      write_base(20'd1015800);
      release_all_live();

      // Window moved between allocation and free.
      write_base(20'hFFFF0);
      for (int i = 0; i < 6; i++) push_alloc($urandom, $urandom_range(8 * 4096, 1));
      wait_drained();
      write_base(20'd5);
      release_all_live();

      // Hold responses off while requests keep coming, so results back up in the output register.
      hold_req = 1'b1;
      for (int i = 0; i < 20; i++) push_alloc($urandom, $urandom_range(2, 0));
      wait_drained();

      // Random phases, each under its own window base.
      while (n_items < 540) begin
         case ($urandom_range(3))
            0:       write_base(20'd0);
            1:       write_base(20'd1015807);
            default: write_base(20'($urandom_range(1015807)));
         endcase
         random_batch(24);
         wait_drained();
         if ($urandom_range(3) == 0) release_all_live();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/pwa_pkg.sv
src/pwa_req_if.sv
src/pwa_rsp_if.sv
src/pwa_csr_if.sv
src/page_window_allocator.sv
src/pwa_checker.sv
verif/testbench.sv
